@@ rtl/sprite_animation_sequencer_core_macros.svh @@
// ----------------------------------------------------------------------------
// Sprite animation sequencer assertion macros
// Concurrent assertion helpers shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIMATION_SEQUENCER_CORE_MACROS_SVH
`define SPRITE_ANIMATION_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SPR_ANIM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define SPR_ANIM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPR_ANIM_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define SPR_ANIM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

@@ rtl/spr_anim_pkg.sv @@
// ----------------------------------------------------------------------------
// Sprite animation sequencer package
// Payload types, configuration types and codes shared by the sequencer RTL.
// ----------------------------------------------------------------------------
package spr_anim_pkg;

    localparam int FRAME_W     = 6;
    localparam int FRAME_LIMIT = 64;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_SELECT = 2'd2;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_SINGLE   = 2'd1;
    localparam logic [1:0] MODE_CYCLE    = 2'd2;
    localparam logic [1:0] MODE_SEQUENCE = 2'd3;

    localparam logic [1:0] REG_ANIM_MODE   = 2'd0;
    localparam logic [1:0] REG_ONE_SHOT    = 2'd1;
    localparam logic [1:0] REG_ANIM_SPEED  = 2'd2;
    localparam logic [1:0] REG_FRAME_COUNT = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         animation_number;
        logic [3:0]         entry_position;
        logic [FRAME_W-1:0] entry_frame;
        logic               entry_is_end;
    } in_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] current_frame;
        logic               anim_done;
    } out_item_t;

    typedef struct packed {
        logic               is_end;
        logic [FRAME_W-1:0] frame;
    } seq_entry_t;

    typedef struct packed {
        logic [1:0] anim_mode;
        logic       one_shot;
        logic [7:0] anim_speed;
        logic [6:0] frame_count;
    } cfg_t;

endpackage

@@ rtl/spr_anim_store.sv @@
// ----------------------------------------------------------------------------
// Sprite animation sequence store
// One write port and two registered read ports; a write to the address being
// read in the same cycle is passed straight to that read port.
// ----------------------------------------------------------------------------
module spr_anim_store
    import spr_anim_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  seq_entry_t        wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output seq_entry_t        rd_data_a,
    output seq_entry_t        rd_data_b
);

    seq_entry_t mem_reg [DEPTH];
    seq_entry_t rd_data_a_reg;
    seq_entry_t rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr_a)) begin
            rd_data_a_reg <= wr_data;
        end else begin
            rd_data_a_reg <= mem_reg[rd_addr_a];
        end
        if (wr_en && (wr_addr == rd_addr_b)) begin
            rd_data_b_reg <= wr_data;
        end else begin
            rd_data_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

@@ rtl/spr_anim_engine.sv @@
// ----------------------------------------------------------------------------
// Sprite animation sequencer engine
// Holds the animation state, applies one item per execute cycle and keeps the
// store read ports pointed at the entries the next item may need.
// ----------------------------------------------------------------------------
`include "sprite_animation_sequencer_core_macros.svh"

module spr_anim_engine
    import spr_anim_pkg::*;
#(
    parameter int NUM_ANIMATIONS  = 16,
    parameter int SEQUENCE_LENGTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      exec,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result_next
);

    localparam int DEPTH  = NUM_ANIMATIONS * SEQUENCE_LENGTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(SEQUENCE_LENGTH);
    localparam int SEL_W  = (NUM_ANIMATIONS > 1) ? $clog2(NUM_ANIMATIONS) : 1;

    logic [7:0]         tick_reg,  tick_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [SEL_W-1:0]   sel_reg,   sel_next;
    logic               done_reg,  done_next;
    seq_entry_t         cur_entry_reg, cur_entry_next;

    seq_entry_t        rd_a;
    seq_entry_t        rd_b;
    seq_entry_t        fallback;
    seq_entry_t        load_entry;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;

    logic [8:0]  tick_inc;
    logic        advance;
    logic [6:0]  frame_inc;
    logic [15:0] pos_inc;
    logic        seq_has_next;
    logic        anim_ok;
    logic        pos_ok;
    logic [15:0] load_addr;
    logic [15:0] cur_addr;
    logic [15:0] next_base;
    logic [15:0] next_pos_inc;

    assign tick_inc     = {1'b0, tick_reg} + 9'd1;
    assign advance      = tick_inc >= {1'b0, cfg.anim_speed};
    assign frame_inc    = {1'b0, frame_reg} + 7'd1;
    assign pos_inc      = 16'(pos_reg) + 16'd1;
    assign seq_has_next = (pos_inc < 16'(SEQUENCE_LENGTH)) && !rd_a.is_end;
    assign fallback     = (cfg.one_shot && (pos_reg != '0)) ? cur_entry_reg : rd_b;
    assign anim_ok      = 16'(item.animation_number) < 16'(NUM_ANIMATIONS);
    assign pos_ok       = 16'(item.entry_position) < 16'(SEQUENCE_LENGTH);
    assign load_addr    = 16'(item.animation_number) * 16'(SEQUENCE_LENGTH)
                          + 16'(item.entry_position);
    assign cur_addr     = 16'(sel_reg) * 16'(SEQUENCE_LENGTH) + 16'(pos_reg);
    assign load_entry   = '{is_end: item.entry_is_end, frame: item.entry_frame};

    always_comb begin
        tick_next      = tick_reg;
        frame_next     = frame_reg;
        pos_next       = pos_reg;
        sel_next       = sel_reg;
        done_next      = done_reg;
        cur_entry_next = cur_entry_reg;
        wr_en          = 1'b0;
        if (!aresetn) begin
            tick_next  = '0;
            frame_next = '0;
            pos_next   = '0;
            sel_next   = '0;
            done_next  = 1'b0;
        end else if (exec) begin
            case (item.opcode)
                OP_TICK: begin
                    case (cfg.anim_mode)
                        MODE_SINGLE: begin
                            frame_next = '0;
                        end
                        MODE_CYCLE: begin
                            if (advance) begin
                                tick_next = '0;
                                if ((frame_inc >= cfg.frame_count) ||
                                    (frame_inc >= 7'(FRAME_LIMIT)) || frame_inc[6]) begin
                                    frame_next = '0;
                                end else begin
                                    frame_next = frame_inc[FRAME_W-1:0];
                                end
                            end else begin
                                tick_next = tick_inc[7:0];
                            end
                        end
                        MODE_SEQUENCE: begin
                            if (advance) begin
                                tick_next = '0;
                                if (seq_has_next) begin
                                    pos_next       = pos_inc[POS_W-1:0];
                                    frame_next     = rd_a.frame;
                                    cur_entry_next = rd_a;
                                end else begin
                                    if (cfg.one_shot) begin
                                        done_next = 1'b1;
                                    end else begin
                                        pos_next = '0;
                                    end
                                    if (!fallback.is_end) begin
                                        frame_next = fallback.frame;
                                    end
                                end
                            end else begin
                                tick_next = tick_inc[7:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_LOAD: begin
                    if (anim_ok && pos_ok) begin
                        wr_en = 1'b1;
                        if (load_addr == cur_addr) begin
                            cur_entry_next = load_entry;
                        end
                    end
                end
                OP_SELECT: begin
                    if (anim_ok) begin
                        sel_next = SEL_W'(item.animation_number);
                        pos_next = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign next_base    = 16'(sel_next) * 16'(SEQUENCE_LENGTH);
    assign next_pos_inc = 16'(pos_next) + 16'd1;
    assign rd_addr_a    = (next_pos_inc < 16'(SEQUENCE_LENGTH)) ?
                          ADDR_W'(next_base + next_pos_inc) : ADDR_W'(next_base);
    assign rd_addr_b    = ADDR_W'(next_base);

    always_ff @(posedge aclk) begin
        tick_reg      <= tick_next;
        frame_reg     <= frame_next;
        pos_reg       <= pos_next;
        sel_reg       <= sel_next;
        done_reg      <= done_next;
        cur_entry_reg <= cur_entry_next;
    end

    spr_anim_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (ADDR_W'(load_addr)),
        .wr_data   (load_entry),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign result_next = '{current_frame: frame_next, anim_done: done_next};

    `SPR_ANIM_ASSERT_NEXT(a_done_sticky, aclk, aresetn, done_reg, done_reg,
        "Done flag cleared without reset")
    `SPR_ANIM_ASSERT_SAME(a_pos_in_range, aclk, aresetn, 1'b1,
        (32'(pos_reg) < 32'(SEQUENCE_LENGTH)), "Sequence position beyond table")
    `SPR_ANIM_ASSERT_NEXT(a_select_rewinds, aclk, aresetn,
        (exec && (item.opcode == OP_SELECT) && anim_ok),
        ((pos_reg == '0) && (32'(sel_reg) < 32'(NUM_ANIMATIONS))),
        "Select did not rewind the sequence")

endmodule

@@ rtl/sprite_animation_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// Sprite animation sequencer core
// Input register, sequencer engine, result register and APB register bank.
// ----------------------------------------------------------------------------
// The input item and the result are each held in a register.
// Throughput: one item per cycle while results are taken; a tick reads at most
// two store entries, both served by the store's two registered read ports.
// Reset (synchronous, active low) clears the animation state, the handshake
// state and the registers; sequence store contents are undefined until loaded.
module sprite_animation_sequencer_core
    import spr_anim_pkg::*;
#(
    parameter int NUM_ANIMATIONS  = 16,
    parameter int SEQUENCE_LENGTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       in_valid_reg,  in_valid_next;
    in_item_t   in_item_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg;
    logic [1:0] anim_mode_reg;
    logic       one_shot_reg;
    logic [7:0] anim_speed_reg;
    logic [6:0] frame_count_reg;

    logic       exec;
    logic       cfg_wr;
    cfg_t       cfg;
    out_item_t  result_next;

    assign exec    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || exec;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign cfg = '{anim_mode: anim_mode_reg, one_shot: one_shot_reg,
                   anim_speed: anim_speed_reg, frame_count: frame_count_reg};

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (exec) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ANIM_MODE:   prdata = 32'(anim_mode_reg);
            REG_ONE_SHOT:    prdata = 32'(one_shot_reg);
            REG_ANIM_SPEED:  prdata = 32'(anim_speed_reg);
            REG_FRAME_COUNT: prdata = 32'(frame_count_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            anim_mode_reg   <= MODE_NONE;
            one_shot_reg    <= 1'b0;
            anim_speed_reg  <= '0;
            frame_count_reg <= 7'd1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_ANIM_MODE:   anim_mode_reg   <= pwdata[1:0];
                    REG_ONE_SHOT:    one_shot_reg    <= pwdata[0];
                    REG_ANIM_SPEED:  anim_speed_reg  <= pwdata[7:0];
                    REG_FRAME_COUNT: frame_count_reg <= pwdata[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (exec) begin
            out_item_reg <= result_next;
        end
    end

    spr_anim_engine #(
        .NUM_ANIMATIONS  (NUM_ANIMATIONS),
        .SEQUENCE_LENGTH (SEQUENCE_LENGTH)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .exec        (exec),
        .item        (in_item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

endmodule

@@ tb/tb_sprite_animation_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite animation sequencer core testbench
// A short directed table followed by randomized phases of ticks, sequence
// loads and selects. Each phase uses its own register setting. Every result
// transfer is checked against a given or in-bench predicted frame and done
// flag, under random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_sprite_animation_sequencer_core;
    import spr_anim_pkg::*;

    localparam int ANIMS        = 16;
    localparam int SEQ_LEN      = 16;
    localparam int RANDOM_ITEMS = 480;
    localparam int PHASES       = 12;
    localparam int STALL_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    localparam logic [1:0] OP_NOP = 2'd3;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

    typedef struct {
        row_kind_e kind;
        cfg_t      cfg;
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    seq_entry_t  seq_mem [ANIMS*SEQ_LEN];
    bit          seq_written [ANIMS*SEQ_LEN];
    logic [7:0]  tick_cnt;
    logic [5:0]  frame_now;
    logic [3:0]  seq_pos;
    logic [3:0]  sel_anim;
    logic        done_flag;
    cfg_t        cfg_now;

    out_item_t   pending_display[$];
    out_item_t   display_head;
    dir_row_t    dir_tab[$];
    int          errors;
    int          cycle_count;
    int          accepted_items;
    int          stall_left;
    bit          calm;
    bit          stall_request;

    sprite_animation_sequencer_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void note_error(string msg);
        errors++;
        if (errors <= REPORT_MAX) begin
            $display("MISMATCH: %s", msg);
        end
    endfunction

    function automatic int entry_addr(int p);
        return int'(sel_anim) * SEQ_LEN + p;
    endfunction

    function automatic bit prescaler_due();
        return (int'(tick_cnt) + 1) >= int'(cfg_now.anim_speed);
    endfunction

    function automatic void step_sequence();
        int         next_pos;
        seq_entry_t e;
        bit         at_end;
        next_pos = int'(seq_pos) + 1;
        at_end = 1'b1;
        if (next_pos < SEQ_LEN) begin
            e = seq_mem[entry_addr(next_pos)];
            if (!e.is_end) begin
                at_end = 1'b0;
                seq_pos = next_pos[3:0];
                frame_now = e.frame;
            end
        end
        if (at_end) begin
            if (cfg_now.one_shot) begin
                done_flag = 1'b1;
            end else begin
                seq_pos = '0;
            end
            e = seq_mem[entry_addr(int'(seq_pos))];
            if (!e.is_end) begin
                frame_now = e.frame;
            end
        end
    endfunction

    function automatic out_item_t next_display(in_item_t it);
        int f;
        case (it.opcode)
            OP_TICK: begin
                if (cfg_now.anim_mode == MODE_SINGLE) begin
                    frame_now = '0;
                end else if (cfg_now.anim_mode == MODE_CYCLE ||
                             cfg_now.anim_mode == MODE_SEQUENCE) begin
                    if (prescaler_due()) begin
                        tick_cnt = '0;
                        if (cfg_now.anim_mode == MODE_CYCLE) begin
                            f = int'(frame_now) + 1;
                            if (f >= int'(cfg_now.frame_count) || f >= FRAME_LIMIT) begin
                                f = 0;
                            end
                            frame_now = f[5:0];
                        end else begin
                            step_sequence();
                        end
                    end else begin
                        tick_cnt = tick_cnt + 8'd1;
                    end
                end
            end
            OP_LOAD: begin
                f = int'(it.animation_number) * SEQ_LEN + int'(it.entry_position);
                seq_mem[f] = seq_entry_t'{it.entry_is_end, it.entry_frame};
                seq_written[f] = 1'b1;
            end
            OP_SELECT: begin
                sel_anim = it.animation_number;
                seq_pos = '0;
            end
            default: begin
            end
        endcase
        return out_item_t'{frame_now, done_flag};
    endfunction

    // Address of a never-loaded entry that the next tick would look at, or -1.
    function automatic int unwritten_read();
        int next_pos;
        int p;
        if (cfg_now.anim_mode != MODE_SEQUENCE || !prescaler_due()) begin
            return -1;
        end
        next_pos = int'(seq_pos) + 1;
        if (next_pos < SEQ_LEN) begin
            if (!seq_written[entry_addr(next_pos)]) begin
                return entry_addr(next_pos);
            end
            if (!seq_mem[entry_addr(next_pos)].is_end) begin
                return -1;
            end
        end
        p = cfg_now.one_shot ? int'(seq_pos) : 0;
        if (!seq_written[entry_addr(p)]) begin
            return entry_addr(p);
        end
        return -1;
    endfunction

    function automatic in_item_t mk(logic [1:0] op, logic [3:0] anim, logic [3:0] pos,
                                    logic [5:0] frame, logic is_end);
        return in_item_t'{op, anim, pos, frame, is_end};
    endfunction

    function automatic dir_row_t item_row(in_item_t it, bit typed = 1'b0,
                                          out_item_t want = '0);
        return '{ROW_ITEM, cfg_t'('0), it, typed, want};
    endfunction

    function automatic dir_row_t cfg_row(cfg_t c);
        return '{ROW_CFG, c, in_item_t'('0), 1'b0, out_item_t'('0)};
    endfunction

    task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
        out_item_t predicted;
        while (!calm && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = next_display(it);
        pending_display.push_back(typed ? want : predicted);
        if (it.opcode != OP_NOP) begin
            accepted_items++;
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_display.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [1:0] idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
    endtask

    task automatic check_reg(logic [1:0] idx, logic [31:0] want);
        logic [31:0] got;
        apb_access(1'b0, idx, 32'd0, got);
        if (got !== want) begin
            note_error($sformatf("register %0d read exp %h got %h", idx, want, got));
        end
    endtask

    task automatic set_config(cfg_t c);
        logic [31:0] unused;
        apb_access(1'b1, REG_ANIM_MODE, {30'd0, c.anim_mode}, unused);
        apb_access(1'b1, REG_ONE_SHOT, {31'd0, c.one_shot}, unused);
        apb_access(1'b1, REG_ANIM_SPEED, {24'd0, c.anim_speed}, unused);
        apb_access(1'b1, REG_FRAME_COUNT, {25'd0, c.frame_count}, unused);
        cfg_now = c;
        check_reg(REG_ANIM_MODE, {30'd0, c.anim_mode});
        check_reg(REG_ONE_SHOT, {31'd0, c.one_shot});
        check_reg(REG_ANIM_SPEED, {24'd0, c.anim_speed});
        check_reg(REG_FRAME_COUNT, {25'd0, c.frame_count});
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_item();
        logic [16:0] raw;
        in_item_t    it;
        int          roll;
        int          missing;
        int          len;
        int          tmp;
        raw = $urandom;
        it = raw;
        roll = $urandom_range(99);
        if (roll < 8) begin
            // A whole sequence: frames, then an end mark, or a full table with none.
            len = $urandom_range(1, SEQ_LEN);
            it.opcode = OP_LOAD;
            for (int p = 0; p < len; p++) begin
                it.entry_position = p[3:0];
                it.entry_frame = $urandom_range(63);
                it.entry_is_end = (p == len - 1) && !(len == SEQ_LEN && $urandom_range(1) == 1);
                send_item(it);
            end
        end else begin
            if (roll < 16) begin
                it.opcode = OP_LOAD;
            end else if (roll < 25) begin
                it.opcode = OP_SELECT;
            end else if (roll < 28) begin
                it.opcode = OP_NOP;
            end else begin
                missing = unwritten_read();
                if (missing >= 0) begin
                    it.opcode = OP_LOAD;
                    tmp = missing / SEQ_LEN;
                    it.animation_number = tmp[3:0];
                    tmp = missing % SEQ_LEN;
                    it.entry_position = tmp[3:0];
                end else begin
                    it.opcode = OP_TICK;
                end
            end
            send_item(it);
        end
    endtask

    initial begin
        m_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (stall_request) begin
                stall_request = 1'b0;
                stall_left = STALL_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_display.size() == 0) begin
                note_error($sformatf("unexpected result frame %0d done %0d",
                                     m_item.current_frame, m_item.anim_done));
            end else begin
                display_head = pending_display.pop_front();
                if (m_item.current_frame !== display_head.current_frame ||
                    m_item.anim_done !== display_head.anim_done) begin
                    note_error($sformatf("frame exp %0d got %0d, done exp %0d got %0d",
                                         display_head.current_frame, m_item.current_frame,
                                         display_head.anim_done, m_item.anim_done));
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        cfg_t c;
        int   target;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        accepted_items = 0;
        calm = 1'b0;
        stall_request = 1'b0;
        tick_cnt = '0;
        frame_now = '0;
        seq_pos = '0;
        sel_anim = '0;
        done_flag = 1'b0;
        cfg_now = cfg_t'{MODE_NONE, 1'b0, 8'd0, 7'd1};

        dir_tab.push_back(item_row(mk(OP_TICK, 4'd0, 4'd0, 6'd0, 1'b0), 1'b1, '{6'd0, 1'b0}));
        dir_tab.push_back(item_row(mk(OP_NOP, 4'd15, 4'd15, 6'd63, 1'b1), 1'b1, '{6'd0, 1'b0}));
        dir_tab.push_back(item_row(mk(OP_LOAD, 4'd0, 4'd0, 6'd63, 1'b0), 1'b1, '{6'd0, 1'b0}));
        dir_tab.push_back(item_row(mk(OP_LOAD, 4'd0, 4'd1, 6'd5, 1'b0)));
        dir_tab.push_back(item_row(mk(OP_LOAD, 4'd0, 4'd2, 6'd42, 1'b1)));
        dir_tab.push_back(item_row(mk(OP_LOAD, 4'd1, 4'd0, 6'd9, 1'b1)));
        dir_tab.push_back(item_row(mk(OP_LOAD, 4'd1, 4'd1, 6'd0, 1'b1)));
        dir_tab.push_back(item_row(mk(OP_LOAD, 4'd15, 4'd15, 6'd63, 1'b1)));
        dir_tab.push_back(cfg_row(cfg_t'{MODE_CYCLE, 1'b0, 8'd0, 7'd3}));
        repeat (4) dir_tab.push_back(item_row(mk(OP_TICK, 4'd0, 4'd0, 6'd0, 1'b0)));
        dir_tab.push_back(cfg_row(cfg_t'{MODE_SEQUENCE, 1'b0, 8'd2, 7'd64}));
        dir_tab.push_back(item_row(mk(OP_SELECT, 4'd0, 4'd0, 6'd0, 1'b0)));
        repeat (4) dir_tab.push_back(item_row(mk(OP_TICK, 4'd0, 4'd0, 6'd0, 1'b0)));
        // Empty sequence: the frame holds and the position stays at zero.
        dir_tab.push_back(item_row(mk(OP_SELECT, 4'd1, 4'd0, 6'd0, 1'b0)));
        repeat (2) dir_tab.push_back(item_row(mk(OP_TICK, 4'd0, 4'd0, 6'd0, 1'b0)));
        dir_tab.push_back(cfg_row(cfg_t'{MODE_SEQUENCE, 1'b1, 8'd0, 7'd64}));
        dir_tab.push_back(item_row(mk(OP_SELECT, 4'd0, 4'd0, 6'd0, 1'b0)));
        repeat (2) dir_tab.push_back(item_row(mk(OP_TICK, 4'd0, 4'd0, 6'd0, 1'b0)));
        dir_tab.push_back(cfg_row(cfg_t'{MODE_SINGLE, 1'b0, 8'd0, 7'd1}));
        dir_tab.push_back(item_row(mk(OP_TICK, 4'd15, 4'd15, 6'd63, 1'b1)));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                wait_drained();
                set_config(dir_tab[i].cfg);
            end else begin
                send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: c = cfg_t'{MODE_SEQUENCE, 1'b0, 8'd0, 7'd1};
                1: c = cfg_t'{MODE_CYCLE, 1'b0, 8'd255, 7'd127};
                2: c = cfg_t'{MODE_CYCLE, 1'b0, 8'd1, 7'd0};
                3: c = cfg_t'{MODE_SEQUENCE, 1'b0, 8'd1, 7'd64};
                4: c = cfg_t'{MODE_CYCLE, 1'b1, 8'd0, 7'd64};
                5: c = cfg_t'{MODE_NONE, 1'b0, 8'd7, 7'd5};
                6: c = cfg_t'{MODE_SEQUENCE, 1'b1, 8'd0, 7'd64};
                default: begin
                    c.anim_mode = ($urandom_range(9) < 6) ? MODE_SEQUENCE
                                                          : 2'($urandom_range(3));
                    c.one_shot = 1'($urandom_range(1));
                    c.anim_speed = 8'($urandom_range(3));
                    c.frame_count = 7'($urandom_range(1, 64));
                end
            endcase
            wait_drained();
            set_config(c);
            calm = (ph == 0);
            if (ph == 3) begin
                stall_request = 1'b1;
            end
            target = accepted_items + RANDOM_ITEMS / PHASES;
            while (accepted_items < target) random_item();
        end

        calm = 1'b0;
        wait_drained();
        repeat (8) @(negedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
